FILE: hw/rtl/msde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msde_pkg
// Shared types and helpers for the Menger slice distance estimate unit.
// ----------------------------------------------------------------------------
package msde_pkg;

	// Four coordinates of the slice: x, y, z, w.
	localparam int NCOORD = 4;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// ceil(2^33 / 3): reciprocal of three for exact unsigned floor division.
	localparam logic [31:0] UDIV3_K = 32'd2863311531;

	// Control word that the sequencer hands to every cell of the chain.
	typedef struct packed {
		logic       fwd_en;
		logic       bwd_en;
		logic       flip;
		logic [3:0] depth;
	} msde_ctl_t;

	function automatic logic [31:0] udiv3(input logic [31:0] u);
		logic [63:0] p;
		p = u * UDIV3_K;
		return {1'b0, p[63:33]};
	endfunction

	// Floor division by three of a signed value.
	function automatic logic signed [31:0] fdiv3(input logic signed [31:0] v);
		logic [31:0] m;
		m = 32'(-v) + 32'd2;
		if (!v[31]) begin
			return $signed(udiv3(v));
		end
		return -$signed(udiv3(m));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'(S32_MAX)) begin
			return S32_MAX;
		end
		if (v < 64'(S32_MIN)) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

endpackage

FILE: hw/rtl/msde_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msde_cell
// One refinement level of the sponge chain, for all four coordinates.
// ----------------------------------------------------------------------------
module msde_cell import msde_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int IDX = 1,
	localparam int RW = FRAC_BITS + 3,
	localparam int TW = FRAC_BITS + 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msde_ctl_t            ctl,
	input  logic signed [RW-1:0] r_in [NCOORD],
	output logic signed [RW-1:0] r_out [NCOORD],
	input  logic signed [TW-1:0] v_in [NCOORD],
	input  logic                 v_vld_in,
	output logic signed [TW-1:0] v_out [NCOORD],
	output logic                 v_vld_out
);

	localparam int PW = FRAC_BITS + 5;
	localparam logic signed [PW-1:0] C3 = PW'(3 * (2 ** FRAC_BITS));
	localparam logic signed [PW-1:0] C6 = PW'(6 * (2 ** FRAC_BITS));
	localparam logic signed [TW-1:0] ONEHALF = TW'(3 * (2 ** (FRAC_BITS - 1)));
	localparam logic signed [TW-1:0] HALF = TW'(2 ** (FRAC_BITS - 1));

	logic signed [RW-1:0] r_q [NCOORD];
	logic signed [RW-1:0] r_nx [NCOORD];
	logic signed [TW-1:0] t [NCOORD];
	logic signed [TW-1:0] v_q [NCOORD];
	logic signed [TW-1:0] v_nx [NCOORD];
	logic                 vvld_q;
	logic                 act;

	assign act = (4'(IDX) <= ctl.depth);

	// Residue of the coordinate times 3^IDX modulo three, keeping the sign.
	always_comb begin
		logic signed [PW-1:0] p;
		logic signed [PW-1:0] p3;
		logic signed [PW-1:0] nx;
		for (int k = 0; k < NCOORD; k++) begin
			p = {{(PW - RW){r_in[k][RW-1]}}, r_in[k]};
			p3 = (p <<< 1) + p;
			priority if (p3 >= C6) begin
				nx = p3 - C6;
			end else if (p3 >= C3) begin
				nx = p3 - C3;
			end else if (p3 <= -C6) begin
				nx = p3 + C6;
			end else if (p3 <= -C3) begin
				nx = p3 + C3;
			end else begin
				nx = p3;
			end
			r_nx[k] = nx[RW-1:0];
		end
	end

	always_comb begin
		logic signed [TW-1:0] d;
		logic signed [TW-1:0] a;
		for (int k = 0; k < NCOORD; k++) begin
			d = {{(TW - RW){r_q[k][RW-1]}}, r_q[k]} - ONEHALF;
			a = (d < 0) ? -d : d;
			t[k] = a - HALF;
		end
	end

	// Each triple forms one 3D estimate; the deeper levels fold in divided by three.
	always_comb begin
		logic signed [TW-1:0] m;
		logic signed [TW-1:0] term;
		logic signed [31:0]   f32;
		logic signed [TW-1:0] f;
		for (int j = 0; j < NCOORD; j++) begin
			m = t[j];
			if (t[(j + 1) % NCOORD] > m) begin
				m = t[(j + 1) % NCOORD];
			end
			if (t[(j + 2) % NCOORD] > m) begin
				m = t[(j + 2) % NCOORD];
			end
			term = ctl.flip ? -m : m;
			f32 = fdiv3({{(32 - TW){v_in[j][TW-1]}}, v_in[j]});
			f = f32[TW-1:0];
			if (!v_vld_in) begin
				v_nx[j] = term;
			end else if (ctl.flip) begin
				v_nx[j] = (f > term) ? f : term;
			end else begin
				v_nx[j] = (f < term) ? f : term;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fwd_en) begin
			r_q <= r_nx;
		end
		if (ctl.bwd_en) begin
			v_q <= v_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vvld_q <= 1'b0;
		end else if (ctl.bwd_en) begin
			vvld_q <= act;
		end
	end

	assign r_out = r_q;
	assign v_out = v_q;
	assign v_vld_out = vvld_q;

endmodule

FILE: hw/rtl/menger_slice_distance_estimate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// menger_slice_distance_estimate_unit
// Distance lower bound from a 3D point to a slice of a 4D Menger-like sponge.
// ----------------------------------------------------------------------------
// The block takes one word (pos_x, pos_y, pos_z in Q16.16) and returns one
// word holding a saturated Q16.16 distance bound. Items are worked one at a
// time: the work on an item is set by the single shared 32x32 multiplier,
// which handles eleven products in sequence, and by the cell chain, which is
// swept forward once to build the residues for every level and backward once
// to fold the levels together. The output register lets a new word be
// accepted while a result waits. Registers are to be written over the APB
// port only while the block is idle; the block itself does not enforce this.
// The depth value that the cell chain uses is clamped to MAX_DEPTH; the
// depth register itself holds the value as written.
module menger_slice_distance_estimate_unit import msde_pkg::*; #(
	parameter int MAX_DEPTH = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // distance [31:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW = FRAC_BITS + 3;
	localparam int TW = FRAC_BITS + 4;
	localparam int CW = $clog2((MAX_DEPTH > 5) ? MAX_DEPTH : 5);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MX   = 4'd1;
	localparam logic [3:0] ST_CRD  = 4'd2;
	localparam logic [3:0] ST_MC   = 4'd3;
	localparam logic [3:0] ST_SEED = 4'd4;
	localparam logic [3:0] ST_FWD  = 4'd5;
	localparam logic [3:0] ST_BWD  = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;
	localparam logic [3:0] ST_MS   = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	localparam logic [2:0] REG_SCALE = 3'd0;
	localparam logic [2:0] REG_INV   = 3'd1;
	localparam logic [2:0] REG_DEPTH = 3'd2;
	localparam logic [2:0] REG_SLICE = 3'd3;
	localparam logic [2:0] REG_FLIP  = 3'd4;

	localparam logic [30:0] ONE31 = 31'(2 ** FRAC_BITS);
	localparam logic signed [34:0] ONE35 = 35'(2 ** FRAC_BITS);
	localparam logic signed [33:0] HALF34 = 34'(2 ** (FRAC_BITS - 1));
	localparam logic signed [32:0] ONE33 = 33'(2 ** FRAC_BITS);

	// Configuration registers.
	logic [30:0]        scale_q;
	logic [30:0]        inv_q;
	logic [3:0]         depth_q;
	logic signed [31:0] slice_q;
	logic               flip_q;
	logic               wr_en;

	// Sequencer.
	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [3:0]    dep;
	msde_ctl_t     ctl;

	// Datapath registers.
	logic signed [31:0] pq_q [3];
	logic signed [31:0] coord_q [NCOORD];
	logic signed [31:0] in_q [NCOORD];
	logic signed [RW-1:0] r0_q [NCOORD];
	logic signed [31:0] dd_q [NCOORD];
	logic signed [32:0] acc_q;
	logic signed [63:0] mp_q;
	logic signed [31:0] out_q;
	logic               m_valid_q;

	// Combinational results.
	logic signed [31:0]   mul_a;
	logic [30:0]          mul_b;
	logic signed [31:0]   mres;
	logic signed [31:0]   coord_nx [NCOORD];
	logic signed [RW-1:0] r0_nx [NCOORD];
	logic signed [31:0]   dd_nx [NCOORD];
	logic signed [32:0]   dj;
	logic signed [32:0]   acc_nx;
	logic                 out_load;

	// Cell chain wiring: residues run left to right, folded levels right to left.
	logic signed [RW-1:0] rch [MAX_DEPTH + 1][NCOORD];
	logic signed [TW-1:0] vch [MAX_DEPTH + 2][NCOORD];
	logic                 vvld [MAX_DEPTH + 2];

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= ONE31;
			inv_q <= ONE31;
			depth_q <= 4'd4;
			slice_q <= '0;
			flip_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_SCALE: scale_q <= pwdata[30:0];
				REG_INV:   inv_q <= pwdata[30:0];
				REG_DEPTH: depth_q <= pwdata[3:0];
				REG_SLICE: slice_q <= pwdata;
				REG_FLIP:  flip_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_SCALE: prdata = {1'b0, scale_q};
			REG_INV:   prdata = {1'b0, inv_q};
			REG_DEPTH: prdata = {28'd0, depth_q};
			REG_SLICE: prdata = slice_q;
			REG_FLIP:  prdata = {31'd0, flip_q};
			default:   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- control
	assign dep = (depth_q > 4'(MAX_DEPTH)) ? 4'(MAX_DEPTH) : depth_q;

	always_comb begin
		ctl.fwd_en = (state_q == ST_FWD);
		ctl.bwd_en = (state_q == ST_BWD);
		ctl.flip = flip_q;
		ctl.depth = dep;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_MX;
					end
				end
				ST_MX: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(3)) begin
						cnt_q <= '0;
						state_q <= ST_CRD;
					end
				end
				ST_CRD: begin
					state_q <= ST_MC;
				end
				ST_MC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NCOORD)) begin
						cnt_q <= '0;
						state_q <= ST_SEED;
					end
				end
				ST_SEED: begin
					state_q <= ST_FWD;
				end
				ST_FWD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(MAX_DEPTH - 1)) begin
						cnt_q <= '0;
						state_q <= ST_BWD;
					end
				end
				ST_BWD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(MAX_DEPTH - 1)) begin
						cnt_q <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_MS;
				end
				ST_MS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NCOORD)) begin
						cnt_q <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- multiplier
	// One product is issued per cycle; its registered result is taken in the next cycle.
	always_comb begin
		mul_a = '0;
		mul_b = inv_q;
		unique case (state_q)
			ST_MX: begin
				unique case (cnt_q[1:0])
					2'd0:    mul_a = pq_q[0];
					2'd1:    mul_a = pq_q[1];
					default: mul_a = pq_q[2];
				endcase
			end
			ST_MC: mul_a = coord_q[cnt_q[1:0]];
			ST_MS: begin
				mul_a = dd_q[cnt_q[1:0]];
				mul_b = scale_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mp_q <= mul_a * $signed({1'b0, mul_b});
	end

	assign mres = sat32(mp_q >>> FRAC_BITS);

	// ---------------------------------------------------------------- datapath
	// Map the scaled point onto the four slice coordinates, then to (1 + c) / 2.
	always_comb begin
		logic signed [34:0] ex;
		logic signed [34:0] ey;
		logic signed [34:0] ez;
		logic signed [34:0] q;
		logic signed [34:0] s [NCOORD];
		logic signed [34:0] c;
		ex = {{3{pq_q[0][31]}}, pq_q[0]};
		ey = {{3{pq_q[1][31]}}, pq_q[1]};
		ez = {{3{pq_q[2][31]}}, pq_q[2]};
		q = {{3{slice_q[31]}}, slice_q} >>> 2;
		s[0] = ex + ey - ez;
		s[1] = -ex - ey - ez;
		s[2] = ex - ey + ez;
		s[3] = -ex + ey + ez;
		for (int k = 0; k < NCOORD; k++) begin
			c = (ONE35 + q + (s[k] >>> 1)) >>> 1;
			coord_nx[k] = c[31:0];
		end
	end

	// Truncated residue modulo three: the integer part is reduced, fraction kept.
	always_comb begin
		logic [31:0]   m;
		logic [31:0]   hi;
		logic [31:0]   qh;
		logic [31:0]   rem;
		logic [RW-1:0] rm;
		for (int k = 0; k < NCOORD; k++) begin
			m = in_q[k][31] ? 32'(-in_q[k]) : in_q[k];
			hi = m >> FRAC_BITS;
			qh = udiv3(hi);
			rem = hi - ((qh << 1) + qh);
			rm = {1'b0, rem[1:0], m[FRAC_BITS-1:0]};
			r0_nx[k] = in_q[k][31] ? -$signed(rm) : $signed(rm);
		end
	end

	// Box distance and the folded level result for each 3D estimate.
	always_comb begin
		logic signed [33:0] b [NCOORD];
		logic signed [33:0] d;
		logic signed [33:0] box;
		logic signed [31:0] f32;
		logic signed [33:0] fold;
		for (int k = 0; k < NCOORD; k++) begin
			d = {{2{in_q[k][31]}}, in_q[k]} - HALF34;
			b[k] = ((d < 0) ? -d : d) - HALF34;
		end
		for (int j = 0; j < NCOORD; j++) begin
			box = b[j];
			if (b[(j + 1) % NCOORD] > box) begin
				box = b[(j + 1) % NCOORD];
			end
			if (b[(j + 2) % NCOORD] > box) begin
				box = b[(j + 2) % NCOORD];
			end
			f32 = fdiv3({{(32 - TW){vch[1][j][TW-1]}}, vch[1][j]});
			fold = {{2{f32[31]}}, f32};
			if (dep == 4'd0) begin
				dd_nx[j] = flip_q ? sat32({{30{box[33]}}, box}) : S32_MAX;
			end else if (fold > box) begin
				dd_nx[j] = sat32({{30{fold[33]}}, fold});
			end else begin
				dd_nx[j] = sat32({{30{box[33]}}, box});
			end
		end
	end

	// Each scaled estimate is bounded by the outside distance of the left-out
	// coordinate, then merged with min (union) or max (flip).
	always_comb begin
		logic signed [32:0] c;
		logic signed [32:0] o;
		logic signed [32:0] s;
		c = {coord_q[2'(cnt_q[1:0] + 2'd2)][31], coord_q[2'(cnt_q[1:0] + 2'd2)]};
		if (c > ONE33) begin
			o = c - ONE33;
		end else if (c < 0) begin
			o = -c;
		end else begin
			o = '0;
		end
		s = {mres[31], mres};
		dj = (s > o) ? s : o;
		if (cnt_q == CW'(1)) begin
			acc_nx = dj;
		end else if (flip_q) begin
			acc_nx = (dj > acc_q) ? dj : acc_q;
		end else begin
			acc_nx = (dj < acc_q) ? dj : acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			pq_q[0] <= s_tdata[31:0];
			pq_q[1] <= s_tdata[63:32];
			pq_q[2] <= s_tdata[95:64];
		end
		if (state_q == ST_MX && cnt_q != '0) begin
			pq_q[2'(cnt_q - 1'b1)] <= mres;
		end
		if (state_q == ST_CRD) begin
			coord_q <= coord_nx;
		end
		if (state_q == ST_MC && cnt_q != '0) begin
			in_q[2'(cnt_q - 1'b1)] <= mres;
		end
		if (state_q == ST_SEED) begin
			r0_q <= r0_nx;
		end
		if (state_q == ST_FIN) begin
			dd_q <= dd_nx;
		end
		if (state_q == ST_MS && cnt_q != '0) begin
			acc_q <= acc_nx;
		end
		if (out_load) begin
			out_q <= sat32({{31{acc_q[32]}}, acc_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = out_q;

	// ---------------------------------------------------------------- cell chain
	assign rch[0] = r0_q;
	assign vch[MAX_DEPTH + 1] = '{default: '0};
	assign vvld[0] = 1'b0;
	assign vvld[MAX_DEPTH + 1] = 1'b0;
	assign vch[0] = '{default: '0};

	for (genvar g = 1; g <= MAX_DEPTH; g++) begin : g_cell
		msde_cell #(
			.FRAC_BITS(FRAC_BITS),
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.r_in(rch[g - 1]),
			.r_out(rch[g]),
			.v_in(vch[g + 1]),
			.v_vld_in(vvld[g + 1]),
			.v_out(vch[g]),
			.v_vld_out(vvld[g])
		);
	end

	// ---------------------------------------------------------------- checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MX))
		else $error("accepted word did not start the multiply sequence");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result shown without a finished computation");

	a_load_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result load did not free the sequencer");

	a_depth_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.depth <= 4'(MAX_DEPTH))
		else $error("cell depth exceeds the chain length");

endmodule
